// File: hdl/llsp_pkg.sv
// Shared types, constants and register codes of the lat/lon screen projector.
package llsp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [5:0]  MARKER_SIZE     = 6'd8;
  localparam logic [7:0]  MIN_DISTANCE_PX = 8'd20;
  localparam logic [11:0] EARTH_RADIUS_NM = 12'd3440;

  localparam logic [29:0] MAX_LAT      = 30'd900000000;
  localparam logic [20:0] K_RAD        = 21'd1874033;
  localparam logic [19:0] DIV_RAD      = 20'd1000000;
  localparam logic [31:0] RECIP_RAD_HI = 32'd2251799813;
  localparam logic [24:0] RECIP_RAD_LO = 25'd17592187;
  localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
  localparam logic [29:0] RECIP_7      = 30'd613566757;
  localparam logic [31:0] RECIP_15     = 32'd2290649225;
  localparam logic [30:0] RECIP_3      = 31'd1431655766;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_LAT = 3'd0,
    CFG_OWN_LON = 3'd1,
    CFG_RANGE   = 3'd2,
    CFG_WIDTH   = 3'd3,
    CFG_HEIGHT  = 3'd4,
    CFG_MARKERS = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [30:0] own_lat;
    logic signed [31:0] own_lon;
    logic [9:0]         range_nm;
    logic [11:0]        width;
    logic [11:0]        height;
    logic               markers_en;
  } cfg_t;

  typedef struct packed {
    logic [29:0] alat;
    logic [31:0] mlat;
    logic [32:0] mlon;
    logic        nlat;
    logic        nlon;
  } fr_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hdl/llsp_front.sv
// Front stage: takes a request, forms angle differences and magnitudes, feeds the queue.
module llsp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  llsp_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [30:0]   target_latitude,
  input  logic signed [31:0]   target_longitude,
  input  llsp_pkg::q_stat_t    stat,
  output logic                 push,
  output llsp_pkg::fr_item_t   item
);
  import llsp_pkg::*;

  logic        f_valid;
  fr_item_t    f_item;
  fr_item_t    cls;
  logic [31:0] dlat;
  logic [31:0] slat;
  logic [31:0] aslat;
  logic [30:0] half;
  logic [32:0] dlon;
  logic        accept;

  always_comb begin
    dlat  = {target_latitude[30], target_latitude} - {cfg.own_lat[30], cfg.own_lat};
    slat  = {target_latitude[30], target_latitude} + {cfg.own_lat[30], cfg.own_lat};
    dlon  = {target_longitude[31], target_longitude} - {cfg.own_lon[31], cfg.own_lon};
    aslat = slat[31] ? (~slat + 32'd1) : slat;
    half  = aslat[31:1];
    cls.alat = (half > 31'(MAX_LAT)) ? MAX_LAT : half[29:0];
    cls.mlat = dlat[31] ? (~dlat + 32'd1) : dlat;
    cls.mlon = dlon[32] ? (~dlon + 33'd1) : dlon;
    cls.nlat = dlat[31];
    cls.nlon = dlon[32];
  end

  assign in_stall = f_valid && stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid && !stat.full;
  assign item     = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= cls;
    end
  end

endmodule

// File: hdl/llsp_fifo.sv
// Short request queue between the front stage and the projection pipeline.
module llsp_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  llsp_pkg::fr_item_t   item,
  input  logic                 pop,
  output llsp_pkg::fr_item_t   head,
  output llsp_pkg::q_stat_t    stat
);
  import llsp_pkg::*;

  fr_item_t         mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] cnt;

  assign stat.full  = (cnt == CNT_W'(FIFO_DEPTH));
  assign stat.empty = (cnt == '0);
  assign head       = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp + PTR_W'(1);
      end
      if (pop) begin
        rp <= (rp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + CNT_W'(1);
        2'b01:   cnt <= cnt - CNT_W'(1);
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full) else $error("request pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty) else $error("request popped from an empty queue");
  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> cnt == $past(cnt) + CNT_W'(1)) else $error("queue count missed a push");
  a_cnt_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> cnt == $past(cnt) - CNT_W'(1)) else $error("queue count missed a pop");

endmodule

// File: hdl/llsp_back.sv
// Projection pipeline: radians, cosine, miles, pixels, distance and visibility.
module llsp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  llsp_pkg::cfg_t       cfg,
  input  llsp_pkg::fr_item_t   head,
  input  llsp_pkg::q_stat_t    stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   screen_x,
  output logic signed [15:0]   screen_y,
  output logic [15:0]          distance_px,
  output logic                 visible
);
  import llsp_pkg::*;

  localparam int N_RAD     = 3;
  localparam int N_CMP     = 13;
  localparam int SQ_N      = 28;
  localparam int DV_STEPS  = 4;
  localparam int N_DV      = 28 / DV_STEPS;
  localparam int ST_RAD    = 1;
  localparam int ST_C1     = ST_RAD + N_RAD;
  localparam int ST_SQ     = ST_C1 + N_CMP;
  localparam int ST_DN     = ST_SQ + SQ_N;
  localparam int ST_DV     = ST_DN + 1;
  localparam int ST_FIN    = ST_DV + N_DV;
  localparam int N_ST      = ST_FIN + 1;

  typedef struct packed {
    logic        nlat;
    logic        nlon;
    logic [23:0] rem_r;
    logic [23:0] rem_n;
    logic [23:0] rem_e;
    logic [34:0] qe_r;
    logic [34:0] qe_n;
    logic [34:0] qe_e;
    logic [53:0] q_r;
    logic [53:0] q_n;
    logic [53:0] q_e;
    logic [31:0] x2;
    logic [30:0] t;
    logic [31:0] m;
    logic [15:0] cq;
    logic [32:0] eq;
    logic [30:0] n16;
    logic [30:0] e16;
    logic [26:0] e12;
    logic [26:0] n12;
    logic [53:0] esq;
    logic [53:0] nsq;
    logic [55:0] sv;
    logic [55:0] sr;
    logic [9:0]  rem_x;
    logic [9:0]  rem_y;
    logic [9:0]  rem_d;
    logic [27:0] qx;
    logic [27:0] qy;
    logic [27:0] qd;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [15:0] od;
    logic        ov;
  } bk_t;

  function automatic logic [37:0] rng_div(input logic [37:0] w, input logic [9:0] d);
    logic [10:0] tr;
    logic [9:0]  rem;
    logic [27:0] q;
    rem = w[37:28];
    q   = w[27:0];
    for (int j = 0; j < DV_STEPS; j++) begin
      tr = {rem, q[27]};
      if (tr >= {1'b0, d}) begin
        rem = 10'(tr - {1'b0, d});
        q   = {q[26:0], 1'b1};
      end else begin
        rem = tr[9:0];
        q   = {q[26:0], 1'b0};
      end
    end
    return {rem, q};
  endfunction

  function automatic logic [15:0] sat16(input logic [29:0] v);
    logic [15:0] r;
    if (!v[29] && (v[28:15] != '0)) begin
      r = 16'h7FFF;
    end else if (v[29] && (v[28:15] != '1)) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  bk_t             pipe [N_ST];
  logic [N_ST-1:0] vld;
  logic            adv;
  logic [10:0]     hh;
  logic [10:0]     cx;
  logic [9:0]      rng;

  assign hh  = cfg.height[11:1];
  assign cx  = cfg.width[11:1];
  assign rng = (cfg.range_nm == '0) ? 10'd1 : cfg.range_nm;
  assign adv = !(vld[N_ST-1] && out_stall);
  assign pop = adv && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[N_ST-2:0], !stat.empty};
    end
  end

  for (genvar i = 0; i < N_ST; i++) begin : g_st
    bk_t nx;

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[i] <= nx;
      end
    end

    if (i == 0) begin : g_mul
      always_comb begin
        nx      = '0;
        nx.nlat = head.nlat;
        nx.nlon = head.nlon;
        nx.q_r  = 54'(head.alat) * 54'(K_RAD);
        nx.q_n  = 54'(head.mlat) * 54'(K_RAD);
        nx.q_e  = 54'(head.mlon) * 54'(K_RAD);
      end
    end else if (i == ST_RAD) begin : g_rq
      always_comb begin : c_rq
        logic [63:0] pr;
        logic [63:0] pn;
        logic [63:0] pe;
        nx      = pipe[i-1];
        pr      = 64'(pipe[i-1].q_r[53:22]) * 64'(RECIP_RAD_HI);
        pn      = 64'(pipe[i-1].q_n[53:22]) * 64'(RECIP_RAD_HI);
        pe      = 64'(pipe[i-1].q_e[53:22]) * 64'(RECIP_RAD_HI);
        nx.qe_r = pr[63:29];
        nx.qe_n = pn[63:29];
        nx.qe_e = pe[63:29];
      end
    end else if (i == ST_RAD + 1) begin : g_rr
      always_comb begin : c_rr
        logic [54:0] dr;
        logic [54:0] dn;
        logic [54:0] de;
        nx       = pipe[i-1];
        dr       = 55'(pipe[i-1].q_r) - 55'(pipe[i-1].qe_r) * 55'(DIV_RAD);
        dn       = 55'(pipe[i-1].q_n) - 55'(pipe[i-1].qe_n) * 55'(DIV_RAD);
        de       = 55'(pipe[i-1].q_e) - 55'(pipe[i-1].qe_e) * 55'(DIV_RAD);
        nx.rem_r = dr[23:0];
        nx.rem_n = dn[23:0];
        nx.rem_e = de[23:0];
      end
    end else if (i < ST_C1) begin : g_rc
      always_comb begin : c_rc
        logic [48:0] cr;
        logic [48:0] cn;
        logic [48:0] ce;
        nx     = pipe[i-1];
        cr     = 49'(pipe[i-1].rem_r) * 49'(RECIP_RAD_LO);
        cn     = 49'(pipe[i-1].rem_n) * 49'(RECIP_RAD_LO);
        ce     = 49'(pipe[i-1].rem_e) * 49'(RECIP_RAD_LO);
        nx.q_r = 54'(pipe[i-1].qe_r) + 54'(cr[48:44]);
        nx.q_n = 54'(pipe[i-1].qe_n) + 54'(cn[48:44]);
        nx.q_e = 54'(pipe[i-1].qe_e) + 54'(ce[48:44]);
      end
    end else if (i == ST_C1) begin : g_x2
      always_comb begin : c_x2
        logic [61:0] pr;
        nx    = pipe[i-1];
        pr    = 62'(pipe[i-1].q_r[30:0]) * 62'(pipe[i-1].q_r[30:0]);
        nx.x2 = pr[61:30];
      end
    end else if (i == ST_C1 + 1) begin : g_t1
      always_comb begin : c_t1
        logic [58:0] pr;
        nx   = pipe[i-1];
        pr   = 59'(pipe[i-1].x2[31:3]) * 59'(RECIP_7);
        nx.t = ONE_Q30 - 31'(pr[58:32]);
      end
    end else if (i == ST_C1 + 2 || i == ST_C1 + 4 || i == ST_C1 + 6) begin : g_mx
      always_comb begin : c_mx
        logic [61:0] pr;
        nx   = pipe[i-1];
        pr   = 62'(pipe[i-1].x2) * 62'(pipe[i-1].t);
        nx.m = pr[61:30];
      end
    end else if (i == ST_C1 + 3) begin : g_t2
      always_comb begin : c_t2
        logic [62:0] pr;
        nx   = pipe[i-1];
        pr   = 63'(pipe[i-1].m[31:1]) * 63'(RECIP_15);
        nx.t = ONE_Q30 - 31'(pr[62:35]);
      end
    end else if (i == ST_C1 + 5) begin : g_t3
      always_comb begin : c_t3
        logic [60:0] pr;
        nx   = pipe[i-1];
        pr   = 61'(pipe[i-1].m[31:2]) * 61'(RECIP_3);
        nx.t = ONE_Q30 - 31'(pr[60:32]);
      end
    end else if (i == ST_C1 + 7) begin : g_cos
      always_comb begin : c_cos
        logic [30:0] sub;
        logic [30:0] tt;
        logic [30:0] rs;
        nx  = pipe[i-1];
        sub = pipe[i-1].m[31:1];
        tt  = (sub >= ONE_Q30) ? '0 : ONE_Q30 - sub;
        rs  = tt + 31'd16384;
        nx.cq = (rs[30:15] > 16'd32768) ? 16'd32768 : rs[30:15];
      end
    end else if (i == ST_C1 + 8) begin : g_eq
      always_comb begin : c_eq
        logic [48:0] pe;
        logic [43:0] pn;
        nx     = pipe[i-1];
        pe     = 49'(pipe[i-1].q_e[32:0]) * 49'(pipe[i-1].cq);
        nx.eq  = pe[47:15];
        pn     = 44'(pipe[i-1].q_n[31:0]) * 44'(EARTH_RADIUS_NM) + 44'd8192;
        nx.n16 = 31'(pn[43:14]);
      end
    end else if (i == ST_C1 + 9) begin : g_e16
      always_comb begin : c_e16
        logic [44:0] pe;
        nx     = pipe[i-1];
        pe     = 45'(pipe[i-1].eq) * 45'(EARTH_RADIUS_NM) + 45'd8192;
        nx.e16 = pe[44:14];
      end
    end else if (i == ST_C1 + 10) begin : g_pix
      always_comb begin : c_pix
        logic [42:0] ax;
        logic [42:0] ay;
        logic [31:0] re;
        logic [31:0] rn;
        nx     = pipe[i-1];
        ax     = 43'(pipe[i-1].e16) * 43'(hh) + (43'(rng) << 15);
        ay     = 43'(pipe[i-1].n16) * 43'(hh) + (43'(rng) << 15);
        nx.qx  = 28'(ax[42:16]);
        nx.qy  = 28'(ay[42:16]);
        re     = 32'(pipe[i-1].e16) + 32'd8;
        rn     = 32'(pipe[i-1].n16) + 32'd8;
        nx.e12 = re[30:4];
        nx.n12 = rn[30:4];
      end
    end else if (i == ST_C1 + 11) begin : g_sq
      always_comb begin
        nx     = pipe[i-1];
        nx.esq = 54'(pipe[i-1].e12) * 54'(pipe[i-1].e12);
        nx.nsq = 54'(pipe[i-1].n12) * 54'(pipe[i-1].n12);
      end
    end else if (i == ST_C1 + 12) begin : g_sum
      always_comb begin
        nx    = pipe[i-1];
        nx.sv = 56'(pipe[i-1].esq) + 56'(pipe[i-1].nsq);
        nx.sr = '0;
      end
    end else if (i < ST_DN) begin : g_root
      localparam int SB = 2 * (SQ_N - 1) - 2 * (i - ST_SQ);
      always_comb begin : c_root
        logic [55:0] trial;
        nx    = pipe[i-1];
        trial = pipe[i-1].sr + (56'(1) << SB);
        if (pipe[i-1].sv >= trial) begin
          nx.sv = pipe[i-1].sv - trial;
          nx.sr = (pipe[i-1].sr >> 1) + (56'(1) << SB);
        end else begin
          nx.sr = pipe[i-1].sr >> 1;
        end
      end
    end else if (i == ST_DN) begin : g_dn
      always_comb begin : c_dn
        logic [39:0] ad;
        nx       = pipe[i-1];
        ad       = 40'(pipe[i-1].sr[27:0]) * 40'(hh) + (40'(rng) << 11);
        nx.qd    = ad[39:12];
        nx.rem_x = '0;
        nx.rem_y = '0;
        nx.rem_d = '0;
      end
    end else if (i < ST_FIN) begin : g_div
      always_comb begin
        nx = pipe[i-1];
        {nx.rem_x, nx.qx} = rng_div({pipe[i-1].rem_x, pipe[i-1].qx}, rng);
        {nx.rem_y, nx.qy} = rng_div({pipe[i-1].rem_y, pipe[i-1].qy}, rng);
        {nx.rem_d, nx.qd} = rng_div({pipe[i-1].rem_d, pipe[i-1].qd}, rng);
      end
    end else begin : g_fin
      always_comb begin : c_fin
        logic [29:0] xs;
        logic [29:0] ys;
        nx    = pipe[i-1];
        xs    = pipe[i-1].nlon ? 30'(cx) - 30'(pipe[i-1].qx) : 30'(cx) + 30'(pipe[i-1].qx);
        ys    = pipe[i-1].nlat ? 30'(hh) + 30'(pipe[i-1].qy) : 30'(hh) - 30'(pipe[i-1].qy);
        nx.ox = sat16(xs);
        nx.oy = sat16(ys);
        nx.od = (pipe[i-1].qd > 28'd65535) ? 16'hFFFF : pipe[i-1].qd[15:0];
        nx.ov = cfg.markers_en && (pipe[i-1].qd >= 28'(MIN_DISTANCE_PX)) &&
                ((29'(pipe[i-1].qd) + 29'(MARKER_SIZE)) < 29'(hh));
      end
    end
  end

  assign out_valid   = vld[N_ST-1];
  assign screen_x    = pipe[N_ST-1].ox;
  assign screen_y    = pipe[N_ST-1].oy;
  assign distance_px = pipe[N_ST-1].od;
  assign visible     = pipe[N_ST-1].ov;

endmodule

// File: hdl/latlon_to_screen_projector_core.sv
// Top level of the lat/lon to screen projector: configuration registers and block wiring.
//
// Each input request carries a target latitude and longitude in 1e-7 degree. The block
// projects it equirectangularly about the configured own position and returns one result:
// screen column and row (north up, saturated), scaled distance from the center and a
// visible flag. Both data channels use valid and stall; a request moves on a rising edge
// with valid high and stall low. Configuration is written through cfg_valid, cfg_index and
// cfg_data; cfg_ready is always high, and writes belong in idle periods.
// Throughput is one request per cycle while the receiver does not stall. From acceptance the
// result passes through one front register, the queue, and a 54-stage pipeline
// whose depth is set mostly by the 28-step square root, the cosine series and the range
// divider. When the receiver stalls, the pipeline holds and the result stays on the ports;
// the front keeps taking requests until the four-entry queue fills, then asserts in_stall.
// Reset clears all pipeline and queue control and loads the register defaults: own
// position zero, range 10 nm, 480 by 320 pixels, markers enabled.
module latlon_to_screen_projector_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [30:0]              target_latitude,
  input  logic signed [31:0]              target_longitude,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [15:0]              screen_x,
  output logic signed [15:0]              screen_y,
  output logic [15:0]                     distance_px,
  output logic                            visible,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [llsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [llsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import llsp_pkg::*;

  cfg_t     cfg;
  q_stat_t  stat;
  fr_item_t item;
  fr_item_t head;
  logic     push;
  logic     pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_lat    <= '0;
      cfg.own_lon    <= '0;
      cfg.range_nm   <= 10'd10;
      cfg.width      <= 12'd480;
      cfg.height     <= 12'd320;
      cfg.markers_en <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OWN_LAT: cfg.own_lat    <= cfg_data[30:0];
        CFG_OWN_LON: cfg.own_lon    <= cfg_data[31:0];
        CFG_RANGE:   cfg.range_nm   <= cfg_data[9:0];
        CFG_WIDTH:   cfg.width      <= cfg_data[11:0];
        CFG_HEIGHT:  cfg.height     <= cfg_data[11:0];
        CFG_MARKERS: cfg.markers_en <= cfg_data[0];
        default:     cfg.markers_en <= cfg.markers_en;
      endcase
    end
  end

  llsp_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .target_latitude  (target_latitude),
    .target_longitude (target_longitude),
    .stat             (stat),
    .push             (push),
    .item             (item)
  );

  llsp_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .item (item),
    .pop  (pop),
    .head (head),
    .stat (stat)
  );

  llsp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .stat        (stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .screen_x    (screen_x),
    .screen_y    (screen_y),
    .distance_px (distance_px),
    .visible     (visible)
  );

endmodule

// File: sim/latlon_to_screen_projector_core_tb.sv
// Testbench for the lat/lon screen projector: directed and random targets checked against a local predictor.
module latlon_to_screen_projector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import llsp_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        dpx;
    logic               vis;
  } screen_pos_t;

  localparam longint unsigned DEG_Q30   = 64'd18740330;
  localparam longint unsigned ANGLE_DIV = 64'd10000000;
  localparam longint unsigned ONE_Q30L  = 64'd1073741824;
  localparam longint unsigned LAT_LIMIT = 64'd900000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [30:0] target_latitude = '0;
  logic signed [31:0] target_longitude = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;
  logic [15:0] distance_px;
  logic visible;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  screen_pos_t pending_pos[$];
  int errors = 0;
  int stall_left = 0;
  bit steady = 1'b0;

  longint own_lat_m, own_lon_m;
  longint unsigned range_m, width_m, height_m;
  bit markers_m;

  latlon_to_screen_projector_core u_dut (.*);

  always #4 clk = ~clk;

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned cos_q15(longint unsigned a);
    longint unsigned r, x2, t, sub, c;
    if (a > LAT_LIMIT) a = LAT_LIMIT;
    r = a * DEG_Q30 / ANGLE_DIV;
    x2 = (r * r) >> 30;
    t = ONE_Q30L - x2 / 56;
    t = ONE_Q30L - ((x2 * t) >> 30) / 30;
    t = ONE_Q30L - ((x2 * t) >> 30) / 12;
    sub = ((x2 * t) >> 30) / 2;
    t = sub >= ONE_Q30L ? 0 : ONE_Q30L - sub;
    c = (t + 16384) >> 15;
    return c > 32768 ? 32768 : c;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic screen_pos_t project(longint tlat, longint tlon);
    screen_pos_t p;
    longint dlat, dlon, x, y;
    longint unsigned c, rng, hh, cx, d16, d12, nq, eq, n16, e16, px, py, n12, e12, sq, dpix;
    dlat = tlat - own_lat_m;
    dlon = tlon - own_lon_m;
    c = cos_q15(magnitude(own_lat_m + tlat) >> 1);
    rng = range_m == 0 ? 1 : range_m;
    hh = height_m >> 1;
    cx = width_m >> 1;
    d16 = rng << 16;
    d12 = rng << 12;
    nq = magnitude(dlat) * DEG_Q30 / ANGLE_DIV;
    n16 = (nq * 3440 + 8192) >> 14;
    eq = magnitude(dlon) * DEG_Q30 / ANGLE_DIV;
    eq = (eq * c) >> 15;
    e16 = (eq * 3440 + 8192) >> 14;
    px = (e16 * hh + d16 / 2) / d16;
    py = (n16 * hh + d16 / 2) / d16;
    x = longint'(cx) + (dlon < 0 ? -longint'(px) : longint'(px));
    y = longint'(hh) - (dlat < 0 ? -longint'(py) : longint'(py));
    e12 = (e16 + 8) >> 4;
    n12 = (n16 + 8) >> 4;
    sq = floor_sqrt(e12 * e12 + n12 * n12);
    dpix = (sq * hh + d12 / 2) / d12;
    p.x = clamp16(x);
    p.y = clamp16(y);
    p.dpx = dpix > 65535 ? 16'hFFFF : dpix[15:0];
    p.vis = markers_m && dpix >= 20 && longint'(dpix) < longint'(hh) - 8;
    return p;
  endfunction

  // Results are checked and the output stall is paced on the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_pos.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          screen_pos_t e;
          e = pending_pos.pop_front();
          if (screen_x !== e.x) begin
            $error("screen_x mismatch: expected %0d, actual %0d", e.x, screen_x);
            errors++;
          end
          if (screen_y !== e.y) begin
            $error("screen_y mismatch: expected %0d, actual %0d", e.y, screen_y);
            errors++;
          end
          if (distance_px !== e.dpx) begin
            $error("distance_px mismatch: expected %0d, actual %0d", e.dpx, distance_px);
            errors++;
          end
          if (visible !== e.vis) begin
            $error("visible mismatch: expected %0d, actual %0d", e.vis, visible);
            errors++;
          end
        end
        stall_left = steady ? 0 : $urandom_range(0, 5);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_target(longint tlat, longint tlon);
    int gap;
    longint lat_s;
    longint lon_s;
    lat_s = longint'(signed'(tlat[30:0]));
    lon_s = longint'(signed'(tlon[31:0]));
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    target_latitude <= tlat[30:0];
    target_longitude <= tlon[31:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pos.push_back(project(lat_s, lon_s));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OWN_LAT: own_lat_m = longint'(signed'(value[30:0]));
      CFG_OWN_LON: own_lon_m = longint'(signed'(value));
      CFG_RANGE:   range_m = value[9:0];
      CFG_WIDTH:   width_m = value[11:0];
      CFG_HEIGHT:  height_m = value[11:0];
      CFG_MARKERS: markers_m = value[0];
      default: ;
    endcase
  endtask

  task automatic setup(longint olat, longint olon, int rng, int w, int h, bit mk);
    drain();
    write_reg(CFG_OWN_LAT, olat[31:0]);
    write_reg(CFG_OWN_LON, olon[31:0]);
    write_reg(CFG_RANGE, rng);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_MARKERS, {31'd0, mk});
  endtask

  function automatic longint pick(longint lo, longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  // A target within a few screen ranges of the own position.
  task automatic send_nearby;
    longint span;
    span = longint'(range_m == 0 ? 1 : range_m) * 400000;
    send_target(pick(-900000000, 900000000) == 0 ? 0 :
                own_lat_m + pick(-span, span), own_lon_m + pick(-span, span));
  endtask

  task automatic test_extremes;
    send_target(0, 0);
    send_target(900000000, 1800000000);
    send_target(-900000000, -1800000000);
    send_target(900000000, -1800000000);
    send_target(-900000000, 1800000000);
    send_target(0, 333334);
    send_target(333334, 0);
    send_target(-200000, 250000);
    send_target(1, -1);
  endtask

  task automatic test_special_cases;
    setup(0, 0, 0, 480, 320, 1'b1);
    send_target(10000, 10000);
    send_target(-30000, 2000);
    setup(900000000, -1800000000, 10, 480, 320, 1'b1);
    send_target(900000000, 1800000000);
    send_target(-900000000, -1800000000);
    setup(0, 0, 10, 480, 10, 1'b1);
    send_target(50000, 50000);
    setup(0, 0, 10, 480, 320, 1'b0);
    send_target(500000, 500000);
    setup(-900000000, 1800000000, 1023, 4095, 4095, 1'b1);
    send_target(-899000000, 1790000000);
    send_target(900000000, -1800000000);
    setup(12345678, -98765432, 1, 1, 1, 1'b1);
    send_target(12345678, -98765432);
    send_target(12400000, -98700000);
  endtask

  task automatic test_random;
    for (int ph = 0; ph < 6; ph++) begin
      setup(pick(-900000000, 900000000), pick(-1800000000, 1800000000),
            ph == 0 ? 1023 : $urandom_range(1, 60), $urandom_range(1, 4095),
            ph == 1 ? 4095 : $urandom_range(40, 2000), $urandom_range(0, 3) != 0);
      steady = (ph == 2);
      for (int i = 0; i < 210; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_target(pick(-900000000, 900000000), pick(-1800000000, 1800000000));
        else
          send_nearby();
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    own_lat_m = 0;
    own_lon_m = 0;
    range_m = 10;
    width_m = 480;
    height_m = 320;
    markers_m = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_special_cases();
    test_random();
    drain();
    if (errors == 0)
      $display("PASS latlon_to_screen_projector_core");
    else
      $display("FAIL latlon_to_screen_projector_core");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL latlon_to_screen_projector_core");
    $finish;
  end

endmodule

// File: filelist.f
hdl/llsp_pkg.sv
hdl/llsp_front.sv
hdl/llsp_fifo.sv
hdl/llsp_back.sv
hdl/latlon_to_screen_projector_core.sv
sim/latlon_to_screen_projector_core_tb.sv
